/* hdl/masked_byte_pattern_search_macros.svh */
// Assertion helpers shared by the search RTL.
// Each macro expects clk and rst in scope.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication.
`define MBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mbps_pkg.sv */
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int PAT_STORE     = 16;
  localparam int LEN_W         = 5;
  localparam int ADDR_W        = 48;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DEF_MAX_PAT   = 16;
  localparam int DEF_COUNT_W   = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd4;

  typedef struct packed {
    logic [8*PAT_STORE-1:0] pattern;  // byte j at [8j+7:8j]
    logic [PAT_STORE-1:0]   care;
    logic [LEN_W-1:0]       length;
  } mbps_match_cfg_t;

endpackage

/* hdl/masked_byte_pattern_search.sv */
`timescale 1ns / 1ps
// Masked byte pattern search.
// Input side is a queue: drive data_byte/last_byte with push; a word is taken
// on a rising edge with push high and full low.
// Result side is a queue: while empty is low, found/match_address hold the
// oldest result; it is taken on an edge with pop high.
// A region yields exactly one result: the first match (found=1, address =
// base + offset of match start) or, at last_byte with no match, found=0 and
// address 0. Bytes after a match are ignored until last_byte.
// The front pushes each result into a 4-entry result queue, and the back
// adds the base address on the way into the output register. The front
// takes one byte per cycle while full is low, as its masked window compare
// is combinational.
// Results queue up to 4 deep plus the output register while pop is low;
// full rises only once that queue is full, so a stalled receiver backs up
// into the byte stream.
// Config: wr_en/wr_index/wr_data write a register, no read-back; write only
// while idle. Reset (rst, sync) clears the window, byte count, queue and
// output valid flag, loads pattern length 1, zeroes the other config registers.
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PAT,
  parameter int COUNT_BITS  = DEF_COUNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic                 found,
  output logic [ADDR_W-1:0]    match_address,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  mbps_match_cfg_t       mcfg;
  logic [ADDR_W-1:0]     base_address;
  logic                  take;
  logic                  ev_push, ev_found;
  logic [COUNT_BITS-1:0] ev_offset;
  logic [COUNT_BITS:0]   q_word;
  logic                  q_empty, q_rd;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mcfg.pattern <= '0;
      mcfg.care    <= '0;
      mcfg.length  <= LEN_W'(1);
      base_address <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PAT_LO: mcfg.pattern[63:0]   <= wr_data;
        REG_PAT_HI: mcfg.pattern[127:64] <= wr_data;
        REG_CARE:   mcfg.care            <= wr_data[PAT_STORE-1:0];
        REG_LENGTH: mcfg.length          <= wr_data[LEN_W-1:0];
        REG_BASE:   base_address         <= wr_data[ADDR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign take = push && !full;

  mbps_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (mcfg),
    .ev_push   (ev_push),
    .ev_found  (ev_found),
    .ev_offset (ev_offset)
  );

  mbps_queue #(
    .WIDTH (COUNT_BITS + 1)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (ev_push),
    .wr_word ({ev_found, ev_offset}),
    .q_full  (full),
    .rd      (q_rd),
    .rd_word (q_word),
    .q_empty (q_empty)
  );

  mbps_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .base          (base_address),
    .q_empty       (q_empty),
    .q_found       (q_word[COUNT_BITS]),
    .q_offset      (q_word[COUNT_BITS-1:0]),
    .q_rd          (q_rd),
    .pop           (pop),
    .empty         (empty),
    .found         (found),
    .match_address (match_address)
  );

endmodule

/* hdl/mbps_front.sv */
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_macros.svh"
module mbps_front
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PAT,
  parameter int COUNT_BITS  = DEF_COUNT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  mbps_match_cfg_t       cfg,
  output logic                  ev_push,
  output logic                  ev_found,
  output logic [COUNT_BITS-1:0] ev_offset
);

  localparam int CAP = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [7:0]            win      [CAP];
  logic [7:0]            win_next [CAP];
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic                  match_done;
  logic [LEN_W-1:0]      eff_len;
  logic [CAP-1:0]        slot_ok;
  logic                  hit;

  always_comb begin
    if (cfg.length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.length > CAP_LEN) begin
      eff_len = CAP_LEN;
    end else begin
      eff_len = cfg.length;
    end
  end

  // shifted window: slot 0 is the newest byte
  always_comb begin
    win_next[0] = data_byte;
    for (int k = 1; k < CAP; k++) begin
      win_next[k] = win[k-1];
    end
    cnt_next = (cnt == CNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
  end

  // slot k lines up with pattern byte len-1-k
  always_comb begin
    logic [LEN_W-1:0] j;
    logic [3:0]       jj;
    for (int k = 0; k < CAP; k++) begin
      j  = eff_len - LEN_W'(1) - LEN_W'(k);
      jj = j[3:0];
      if (LEN_W'(k) < eff_len) begin
        slot_ok[k] = !cfg.care[jj] ||
                     (win_next[k] == cfg.pattern[{jj, 3'b000} +: 8]);
      end else begin
        slot_ok[k] = 1'b1;
      end
    end
  end

  assign hit = !match_done && (cnt_next >= COUNT_BITS'(eff_len)) && (&slot_ok);

  always_comb begin
    ev_push   = 1'b0;
    ev_found  = 1'b0;
    ev_offset = '0;
    if (take) begin
      if (hit) begin
        ev_push   = 1'b1;
        ev_found  = 1'b1;
        ev_offset = cnt_next - COUNT_BITS'(eff_len);
      end else if (last_byte && !match_done) begin
        ev_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      match_done <= 1'b0;
      for (int k = 0; k < CAP; k++) win[k] <= '0;
    end else if (take) begin
      if (last_byte) begin
        cnt        <= '0;
        match_done <= 1'b0;
        for (int k = 0; k < CAP; k++) win[k] <= '0;
      end else if (!match_done) begin
        cnt        <= cnt_next;
        match_done <= hit;
        for (int k = 0; k < CAP; k++) win[k] <= win_next[k];
      end
    end
  end

  `MBPS_ASSERT_NEXT(a_last_clears, take && last_byte, cnt == '0 && !match_done, "region end did not clear search state")
  `MBPS_ASSERT_NEXT(a_hit_locks, take && hit && !last_byte, match_done, "match did not lock the region")

endmodule

/* hdl/mbps_queue.sv */
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_macros.svh"
module mbps_queue
  import mbps_pkg::*;
#(
  parameter int WIDTH = 1 + DEF_COUNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_word,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_word,
  output logic             q_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] used;

  assign q_full  = (used == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (used == '0);
  assign rd_word = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (wr) wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (rd) rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      case ({wr, rd})
        2'b10:   used <= used + CNT_W'(1);
        2'b01:   used <= used - CNT_W'(1);
        default: used <= used;
      endcase
    end
  end

  `MBPS_ASSERT_NOW(a_no_overrun, wr, !q_full, "write into full queue")
  `MBPS_ASSERT_NOW(a_no_underrun, rd, !q_empty, "read from empty queue")

endmodule

/* hdl/mbps_back.sv */
`timescale 1ns / 1ps
module mbps_back
  import mbps_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ADDR_W-1:0]     base,
  input  logic                  q_empty,
  input  logic                  q_found,
  input  logic [COUNT_BITS-1:0] q_offset,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output logic                  found,
  output logic [ADDR_W-1:0]     match_address
);

  logic out_valid;

  assign empty = !out_valid;
  assign q_rd  = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // address formed on the way into the output register
  always_ff @(posedge clk) begin
    if (q_rd) begin
      found         <= q_found;
      match_address <= q_found ? base + ADDR_W'(q_offset) : '0;
    end
  end

endmodule

/* tb/sv/masked_byte_pattern_search_tb.sv */
`timescale 1ns / 1ps
module masked_byte_pattern_search_tb;
  import mbps_pkg::*;

  // Run shape
  localparam int IDLE_LIMIT    = 500;  // cycles with no word moving on either side
  localparam int RANDOM_ITEMS  = 950;  // new random phases start until this many byte words are sent
  localparam int QUIET_ITEMS   = 800;  // past this, both sides stream with no idling
  localparam int SETTLE_CYCLES = 6;    // covers the result queue and output register, plus margin

  // Indexes outside the register map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } search_result_t;

  // Scoreboard: mirrors the registers and the search state, predicts one
  // result per region (first match or not-found) and checks what comes out.
  class search_scoreboard;
    logic [CFG_W-1:0]       pat_lo;
    logic [CFG_W-1:0]       pat_hi;
    logic [PAT_STORE-1:0]   care;
    logic [LEN_W-1:0]       len_reg;
    logic [ADDR_W-1:0]      base;
    logic [7:0]             window [PAT_STORE];  // slot 0 is the newest byte
    logic [DEF_COUNT_W-1:0] seen;
    bit                     done;
    search_result_t         awaited [$];
    int                     mismatches;
    int                     checked;
    int                     match_count;

    function new();
      pat_lo      = '0;
      pat_hi      = '0;
      care        = '0;
      len_reg     = LEN_W'(1);
      base        = '0;
      mismatches  = 0;
      checked     = 0;
      match_count = 0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (window[k]) window[k] = '0;
      seen = '0;
      done = 1'b0;
    endfunction

    // zero counts as one, anything past the window is clamped
    function int eff_len();
      int n;
      n = int'(len_reg);
      if (n == 0) n = 1;
      if (n > DEF_MAX_PAT) n = DEF_MAX_PAT;
      if (n > PAT_STORE) n = PAT_STORE;
      return n;
    endfunction

    function logic [7:0] pat_byte(int j);
      logic [8*PAT_STORE-1:0] all;
      all = {pat_hi, pat_lo};
      return all[8*j +: 8];
    endfunction

    function bit window_hit(int n);
      int j;
      for (j = 0; j < n; j++)
        if (care[j] && window[n-1-j] !== pat_byte(j)) return 1'b0;
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PAT_LO: pat_lo  = val;
        REG_PAT_HI: pat_hi  = val;
        REG_CARE:   care    = val[PAT_STORE-1:0];
        REG_LENGTH: len_reg = val[LEN_W-1:0];
        REG_BASE:   base    = val[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the byte took part in the search (not frozen after a match)
    function bit note_byte(logic [7:0] d, logic l);
      int             n;
      int             k;
      bit             hit;
      bit             searched;
      search_result_t r;
      hit      = 1'b0;
      searched = !done;
      if (!done) begin
        n = eff_len();
        for (k = PAT_STORE - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = d;
        if (seen != '1) seen++;
        if (seen >= n && window_hit(n)) begin
          r.found = 1'b1;
          r.addr  = base + ADDR_W'(seen) - ADDR_W'(n);
          awaited.push_back(r);
          done = 1'b1;
          hit  = 1'b1;
          match_count++;
        end
      end
      if (l) begin
        if (!hit && !done) begin
          r.found = 1'b0;
          r.addr  = '0;
          awaited.push_back(r);
        end
        clear_search();
      end
      return searched;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic got_found, logic [ADDR_W-1:0] got_addr);
      search_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word found=%0b addr=%h", got_found, got_addr));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got_found !== want.found)
        report($sformatf("found %0b, want %0b", got_found, want.found));
      if (got_addr !== want.addr)
        report($sformatf("match_address %h, want %h", got_addr, want.addr));
    endtask
  endclass

  // DUT ports, all inputs driven to known values from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  logic [7:0]           data_byte = '0;
  logic                 last_byte = 1'b0;
  logic                 empty;
  logic                 pop       = 1'b0;
  logic                 found;
  logic [ADDR_W-1:0]    match_address;
  logic                 wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index  = '0;
  logic [CFG_W-1:0]     wr_data   = '0;

  search_scoreboard sb;
  int tx_gap_pct     = 0;  // chance per word of an idle burst before it, in percent
  int rx_gap_pct     = 0;  // same for the result side
  int sent_items     = 0;
  int searched_items = 0;
  int regions        = 0;
  int settings       = 0;
  int idle_cycles    = 0;

  masked_byte_pattern_search dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .found         (found),
    .match_address (match_address),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte word. push stays high across back-to-back words; an idle burst
  // drops it first. Outputs are read right at the edge, i.e. pre-update values.
  task automatic send_byte(input logic [7:0] d, input logic l);
    if (tx_gap_pct > 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_items++;
    if (sb.note_byte(d, l)) searched_items++;
    if (l) regions++;
  endtask

  // Result side: pop with random stall bursts, check every word taken
  task automatic drain_results();
    forever begin
      if (rx_gap_pct > 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) sb.check_result(found, match_address);
    end
  endtask

  // Stop pushing, let every expected word come out, then idle for
  // SETTLE_CYCLES as margin.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back, optionally followed by a write to
  // an unmapped index. wr_en stays high through the burst.
  task automatic configure(input logic [CFG_W-1:0] lo, hi, care_v, len_v, base_v,
                           input bit spare);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_W-1:0]     val [6];
    int                   n;
    int                   k;
    idx[0] = REG_PAT_LO;  val[0] = lo;
    idx[1] = REG_PAT_HI;  val[1] = hi;
    idx[2] = REG_CARE;    val[2] = care_v;
    idx[3] = REG_LENGTH;  val[3] = len_v;
    idx[4] = REG_BASE;    val[4] = base_v;
    n = 5;
    if (spare) begin
      case ($urandom_range(0, 2))
        0:       idx[5] = REG_UNMAPPED_5;
        1:       idx[5] = REG_UNMAPPED_6;
        default: idx[5] = REG_UNMAPPED_7;
      endcase
      val[5] = {$urandom, $urandom};
      n = 6;
    end
    for (k = 0; k < n; k++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[k];
      wr_data  <= val[k];
      @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    wr_en <= 1'b0;
    settings++;
  endtask

  // Random setting with extremes mixed in. Unused upper bits of the write
  // data are random so the decode must mask them.
  task automatic random_config();
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] care_v;
    logic [CFG_W-1:0] len_v;
    logic [CFG_W-1:0] base_v;
    lo     = {$urandom, $urandom};
    hi     = {$urandom, $urandom};
    care_v = {$urandom, $urandom};
    len_v  = {$urandom, $urandom};
    base_v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: lo = '0;
      1: lo = '1;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: hi = '0;
      1: hi = '1;
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: care_v[PAT_STORE-1:0] = '0;                             // all wildcards
      1: care_v[PAT_STORE-1:0] = '1;                             // exact match
      2: care_v[PAT_STORE-1:0] = PAT_STORE'($urandom & $urandom); // sparse
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       len_v[LEN_W-1:0] = '0;                             // treated as one
      1:       len_v[LEN_W-1:0] = LEN_W'(16);
      2:       len_v[LEN_W-1:0] = LEN_W'($urandom_range(17, 31)); // clamped
      3:       len_v[LEN_W-1:0] = LEN_W'(1);
      default: len_v[LEN_W-1:0] = LEN_W'($urandom_range(2, 15));
    endcase
    case ($urandom_range(0, 3))
      0: base_v[ADDR_W-1:0] = '0;
      1: base_v[ADDR_W-1:0] = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 40)); // wraps
      default: ;
    endcase
    configure(lo, hi, care_v, len_v, base_v, $urandom_range(0, 2) == 0);
  endtask

  // One region. Filler is half pattern bytes to provoke partial matches.
  // Most regions carry an embedded copy of the pattern (wildcard slots
  // random); some copies get one byte corrupted; the rest is filler only.
  task automatic send_region();
    logic [7:0] bytes [$];
    int         n;
    int         plen;
    int         pos;
    int         j;
    int         k;
    int         shape;
    plen  = sb.eff_len();
    shape = $urandom_range(0, 9);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
    if (shape < 8 && n < plen) n = plen + $urandom_range(0, 3);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 1)) bytes.push_back(sb.pat_byte($urandom_range(0, plen - 1)));
      else bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (shape < 8) begin
      pos = $urandom_range(0, n - plen);
      for (j = 0; j < plen; j++)
        if (sb.care[j]) bytes[pos+j] = sb.pat_byte(j);
      if (shape >= 6) begin
        k = $urandom_range(0, plen - 1);
        bytes[pos+k] = bytes[pos+k] ^ 8'($urandom_range(1, 255));
      end
    end
    for (j = 0; j < n; j++) send_byte(bytes[j], j == n - 1);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // ---- directed part ----
    tx_gap_pct = 20;
    rx_gap_pct = 20;

    // Reset values: length 1, all wildcards, base 0 -> first byte matches
    // at offset 0; the last byte after it is frozen and yields nothing.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Wildcard in the middle, match ending on the final byte (found only,
    // no not-found), address wraps past the top of the 48-bit space.
    settle();
    configure(64'h0000_0000_00CC_5AAA, '1, 64'hFFFF_FFFF_FFFF_0005, 64'd3,
              64'h0000_FFFF_FFFF_FFFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hCC, 1'b1);
    // region shorter than the pattern: not-found
    send_byte(8'h55, 1'b1);

    // Length zero acts as one; unmapped index write must not disturb anything
    settle();
    configure(64'h0000_0000_0000_00FF, '0, 64'd1, 64'd0, 64'h0000_0000_0000_1000, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Length 31 clamps to the full window: sixteen bytes, all cared
    settle();
    configure('1, '0, 64'h0000_0000_0000_FFFF, 64'd31, 64'h0000_8000_0000_0000, 1'b0);
    repeat (8) send_byte(8'hFF, 1'b0);
    repeat (7) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // ---- random part: phases of regions, a new setting between phases ----
    while (sent_items < RANDOM_ITEMS) begin
      settle();
      if (sent_items >= QUIET_ITEMS) begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 10;
          2: tx_gap_pct = 30;
          default: tx_gap_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0: rx_gap_pct = 0;
          1: rx_gap_pct = 10;
          2: rx_gap_pct = 30;
          default: rx_gap_pct = 60;
        endcase
      end
      random_config();
      repeat ($urandom_range(4, 10)) send_region();
    end

    settle();
    $display("sent %0d bytes (%0d searched) over %0d regions under %0d register settings",
             sent_items, searched_items, regions, settings);
    $display("checked %0d result words, %0d of them matches, %0d mismatches",
             sb.checked, sb.match_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mbps_pkg.sv
hdl/mbps_front.sv
hdl/mbps_queue.sv
hdl/mbps_back.sv
hdl/masked_byte_pattern_search.sv
tb/sv/masked_byte_pattern_search_tb.sv
